// File: rtl/core/natpm_pkg.sv
// Shared types and codes of the NAPT port mapping table.
`timescale 1ns / 1ps
package natpm_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PUBLIC_ADDR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_LOW     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_HIGH    = 2'd3;

    localparam logic KIND_OUTBOUND = 1'b0;
    localparam logic KIND_INBOUND  = 1'b1;

    typedef enum logic [1:0] {
        ST_HIT  = 2'd0,
        ST_NEW  = 2'd1,
        ST_MISS = 2'd2,
        ST_FAIL = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_SWEEP,
        S_SEARCH,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [31:0] inner_addr;
        logic [15:0] inner_port;
        logic [31:0] tunnel_addr;
        logic [15:0] tunnel_port;
        logic [15:0] public_port;
    } t_entry;

    typedef struct packed {
        logic data_we;
        logic time_we;
    } t_store_ctl;

endpackage

// File: rtl/core/natpm_in_if.sv
// Request channel of the NAPT port mapping table.
`timescale 1ns / 1ps
interface natpm_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] now_seconds;
    logic [31:0] inner_addr;
    logic [15:0] inner_port;
    logic [31:0] tunnel_addr;
    logic [15:0] tunnel_port;
    logic [31:0] outer_addr;
    logic [15:0] outer_port;

    modport source (output valid, kind, now_seconds, inner_addr, inner_port, tunnel_addr,
                    tunnel_port, outer_addr, outer_port, input ready);
    modport sink (input valid, kind, now_seconds, inner_addr, inner_port, tunnel_addr,
                  tunnel_port, outer_addr, outer_port, output ready);
endinterface

// File: rtl/core/natpm_out_if.sv
// Response channel of the NAPT port mapping table.
`timescale 1ns / 1ps
interface natpm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] result_addr;
    logic [15:0] result_port;
    logic [31:0] result_tunnel_addr;
    logic [15:0] result_tunnel_port;

    modport source (output valid, status, result_addr, result_port, result_tunnel_addr,
                    result_tunnel_port, input ready);
    modport sink (input valid, status, result_addr, result_port, result_tunnel_addr,
                  result_tunnel_port, output ready);
endinterface

// File: rtl/core/natpm_store.sv
// Entry memories: endpoint data and last-use time, one registered read port.
`timescale 1ns / 1ps
module natpm_store
    import natpm_pkg::*;
#(
    parameter int DEPTH = TABLE_ENTRIES_DEF,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic [IDX_W-1:0] i_rd_addr,
    input  t_store_ctl       i_ctl,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_entry           i_wr_data,
    input  logic [31:0]      i_wr_time,
    output t_entry           o_rd_data,
    output logic [31:0]      o_rd_time
);
    t_entry      r_data_mem [DEPTH];
    logic [31:0] r_time_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.data_we) begin
            r_data_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.time_we) begin
            r_time_mem[i_wr_addr] <= i_wr_time;
        end
        o_rd_data <= r_data_mem[i_rd_addr];
        o_rd_time <= r_time_mem[i_rd_addr];
    end
endmodule

// File: rtl/core/natpm_bitmap.sv
// Map of ports in use within the allocation window, filled during the sweep.
`timescale 1ns / 1ps
module natpm_bitmap
    import natpm_pkg::*;
#(
    parameter int DEPTH = TABLE_ENTRIES_DEF,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_clear,
    input  logic           i_set,
    input  logic [15:0]    i_port,
    input  logic [15:0]    i_port_low,
    input  logic [15:0]    i_port_high,
    input  logic [IDX_W:0] i_k,
    output logic           o_used
);
    logic [DEPTH-1:0] r_bits;
    logic [16:0]      offset;
    logic             in_window;

    assign offset    = {1'b0, i_port} - {1'b0, i_port_low};
    assign in_window = (i_port >= i_port_low) && (i_port <= i_port_high) &&
                       (offset < 17'(DEPTH));
    assign o_used    = (i_k < (IDX_W+1)'(DEPTH)) ? r_bits[i_k[IDX_W-1:0]] : 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_bits <= '0;
        end else if (i_set && in_window) begin
            r_bits[offset[IDX_W-1:0]] <= 1'b1;
        end
    end
endmodule

// File: rtl/core/nat_port_mapping_table.sv
// Top level of the NAPT port mapping table: sequencer, registers and valid bits.
// A lookup pass scans the entries for a hit; an outbound miss that needs a new entry
// goes on to an expiry sweep and then a port search.
// Throughput: one request at a time; all passes go through the single entry memory read port.
// Reset: synchronous, active low; clears all valid bits, restores register defaults,
// and the block is ready as soon as reset is released.
`timescale 1ns / 1ps
module nat_port_mapping_table
    import natpm_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    natpm_in_if.sink              i_req,
    natpm_out_if.source           o_rsp
);
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = IDX_W + 1;

    t_state r_state, n_state;

    logic [31:0] r_public_addr;
    logic [15:0] r_idle_timeout, r_port_low, r_port_high;

    logic        r_kind;
    logic [31:0] r_now, r_inner_addr, r_tunnel_addr, r_outer_addr;
    logic [15:0] r_inner_port, r_tunnel_port, r_outer_port;

    logic [CNT_W-1:0] r_addr;
    logic             r_cmp_vld;
    logic [IDX_W-1:0] r_cmp_idx;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [IDX_W-1:0] r_slot;
    logic             r_slot_found;
    logic [CNT_W-1:0] r_k;

    t_status     r_res_status;
    logic [31:0] r_res_addr, r_res_taddr;
    logic [15:0] r_res_port, r_res_tport;

    logic        r_out_valid;
    t_status     r_o_status;
    logic [31:0] r_o_addr, r_o_taddr;
    logic [15:0] r_o_port, r_o_tport;

    t_entry      rd_data, wr_data;
    logic [31:0] rd_time;
    t_store_ctl  st_ctl;
    logic [IDX_W-1:0] wr_addr;

    logic        issue, look_hit, keep, k_end, used, bm_clear, accept, load_out;
    logic [32:0] expiry, now33;
    logic [16:0] cand;
    logic [15:0] cand_port;

    assign accept   = i_req.valid && i_req.ready;
    assign issue    = (r_state == S_LOOK || r_state == S_SWEEP) &&
                      (r_addr < CNT_W'(TABLE_ENTRIES));
    assign expiry   = {1'b0, rd_time} + {17'b0, r_idle_timeout};
    assign now33    = {1'b0, r_now};
    assign cand     = {1'b0, r_port_low} + 17'(r_k);
    assign cand_port = cand[15:0];
    assign k_end    = (r_k >= CNT_W'(TABLE_ENTRIES)) || (cand > {1'b0, r_port_high});
    assign keep     = r_valid[r_cmp_idx] && !(expiry < now33);
    assign load_out = (r_state == S_EMIT) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        if (r_kind == KIND_INBOUND) begin
            look_hit = r_cmp_vld && r_valid[r_cmp_idx] && (r_outer_addr == r_public_addr) &&
                       (rd_data.public_port == r_outer_port) && (expiry > now33);
        end else begin
            look_hit = r_cmp_vld && r_valid[r_cmp_idx] &&
                       (rd_data.inner_addr == r_inner_addr) &&
                       (rd_data.inner_port == r_inner_port) &&
                       (rd_data.tunnel_addr == r_tunnel_addr) &&
                       (rd_data.tunnel_port == r_tunnel_port);
        end
    end

    assign wr_data.inner_addr  = r_inner_addr;
    assign wr_data.inner_port  = r_inner_port;
    assign wr_data.tunnel_addr = r_tunnel_addr;
    assign wr_data.tunnel_port = r_tunnel_port;
    assign wr_data.public_port = cand_port;

    always_comb begin
        n_state        = r_state;
        st_ctl.data_we = 1'b0;
        st_ctl.time_we = 1'b0;
        wr_addr        = r_cmp_idx;
        bm_clear       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (look_hit) begin
                    st_ctl.time_we = 1'b1;
                    n_state        = S_EMIT;
                end else if (!issue && !r_cmp_vld) begin
                    bm_clear = 1'b1;
                    n_state  = (r_kind == KIND_INBOUND) ? S_EMIT : S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (!issue && !r_cmp_vld) begin
                    n_state = r_slot_found ? S_SEARCH : S_EMIT;
                end
            end
            S_SEARCH: begin
                if (k_end) begin
                    n_state = S_EMIT;
                end else if (!used) begin
                    st_ctl.data_we = 1'b1;
                    st_ctl.time_we = 1'b1;
                    wr_addr        = r_slot;
                    n_state        = S_EMIT;
                end
            end
            S_EMIT: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_public_addr  <= '0;
            r_idle_timeout <= 16'd300;
            r_port_low     <= 16'd1024;
            r_port_high    <= 16'd65535;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PUBLIC_ADDR:  r_public_addr  <= i_cfg_data;
                CFG_IDLE_TIMEOUT: r_idle_timeout <= i_cfg_data[15:0];
                CFG_PORT_LOW:     r_port_low     <= i_cfg_data[15:0];
                CFG_PORT_HIGH:    r_port_high    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Scan control, valid bits and result capture.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr       <= '0;
            r_cmp_vld    <= 1'b0;
            r_valid      <= '0;
            r_slot_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_cmp_vld <= issue;
            r_cmp_idx <= r_addr[IDX_W-1:0];
            if (issue) begin
                r_addr <= r_addr + 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_addr <= '0;
                    if (accept) begin
                        r_kind        <= i_req.kind;
                        r_now         <= i_req.now_seconds;
                        r_inner_addr  <= i_req.inner_addr;
                        r_inner_port  <= i_req.inner_port;
                        r_tunnel_addr <= i_req.tunnel_addr;
                        r_tunnel_port <= i_req.tunnel_port;
                        r_outer_addr  <= i_req.outer_addr;
                        r_outer_port  <= i_req.outer_port;
                    end
                end
                S_LOOK: begin
                    if (look_hit) begin
                        r_res_status <= ST_HIT;
                        if (r_kind == KIND_INBOUND) begin
                            r_res_addr  <= rd_data.inner_addr;
                            r_res_port  <= rd_data.inner_port;
                            r_res_taddr <= rd_data.tunnel_addr;
                            r_res_tport <= rd_data.tunnel_port;
                        end else begin
                            r_res_addr  <= r_public_addr;
                            r_res_port  <= rd_data.public_port;
                            r_res_taddr <= '0;
                            r_res_tport <= '0;
                        end
                    end else if (!issue && !r_cmp_vld) begin
                        r_addr       <= '0;
                        r_slot_found <= 1'b0;
                        r_res_status <= ST_MISS;
                        r_res_addr   <= '0;
                        r_res_port   <= '0;
                        r_res_taddr  <= '0;
                        r_res_tport  <= '0;
                    end
                end
                S_SWEEP: begin
                    // Expired entries are dropped; the first free slot after drops is kept.
                    if (r_cmp_vld) begin
                        if (r_valid[r_cmp_idx] && !keep) begin
                            r_valid[r_cmp_idx] <= 1'b0;
                        end
                        if (!keep && !r_slot_found) begin
                            r_slot       <= r_cmp_idx;
                            r_slot_found <= 1'b1;
                        end
                    end
                    r_k          <= '0;
                    r_res_status <= ST_FAIL;
                end
                S_SEARCH: begin
                    if (!k_end) begin
                        if (!used) begin
                            r_valid[r_slot] <= 1'b1;
                            r_res_status    <= ST_NEW;
                            r_res_addr      <= r_public_addr;
                            r_res_port      <= cand_port;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                S_EMIT: ;
                default: ;
            endcase
            if (load_out) begin
                r_out_valid <= 1'b1;
                r_o_status  <= r_res_status;
                r_o_addr    <= r_res_addr;
                r_o_port    <= r_res_port;
                r_o_taddr   <= r_res_taddr;
                r_o_tport   <= r_res_tport;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    natpm_store #(.DEPTH(TABLE_ENTRIES)) u_store (
        .i_clk     (i_clk),
        .i_rd_addr (r_addr[IDX_W-1:0]),
        .i_ctl     (st_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_wr_time (r_now),
        .o_rd_data (rd_data),
        .o_rd_time (rd_time)
    );

    natpm_bitmap #(.DEPTH(TABLE_ENTRIES)) u_bitmap (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (bm_clear),
        .i_set       ((r_state == S_SWEEP) && r_cmp_vld && keep),
        .i_port      (rd_data.public_port),
        .i_port_low  (r_port_low),
        .i_port_high (r_port_high),
        .i_k         (r_k),
        .o_used      (used)
    );

    assign i_req.ready              = (r_state == S_IDLE);
    assign o_rsp.valid              = r_out_valid;
    assign o_rsp.status             = r_o_status;
    assign o_rsp.result_addr        = r_o_addr;
    assign o_rsp.result_port        = r_o_port;
    assign o_rsp.result_tunnel_addr = r_o_taddr;
    assign o_rsp.result_tunnel_port = r_o_tport;

`ifndef SYNTHESIS
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_o_status == ST_MISS || r_o_status == ST_FAIL) |->
        (r_o_addr == '0 && r_o_port == '0 && r_o_taddr == '0 && r_o_tport == '0))
        else $error("failure response carries nonzero fields");
    a_search_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SEARCH |-> r_slot_found)
        else $error("port search without a free slot");
    a_new_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_ctl.data_we |=> r_valid[$past(r_slot)])
        else $error("new entry not marked valid");
    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_ctl.data_we |-> st_ctl.time_we && r_state == S_SEARCH)
        else $error("entry data written outside the port search");
`endif
endmodule

// File: dv/tb_top.sv
// Self-checking testbench of the NAPT port mapping table: directed and random requests.
`timescale 1ns / 1ps
module tb_top;
    import natpm_pkg::*;

    localparam int N_ENTRIES = 256;
    localparam int LIMIT_CYCLES = 2000000;

    typedef struct {
        t_status     status;
        logic [31:0] addr;
        logic [15:0] port;
        logic [31:0] taddr;
        logic [15:0] tport;
    } t_expect;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    natpm_in_if req_if();
    natpm_out_if rsp_if();

    nat_port_mapping_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_req(req_if.sink), .o_rsp(rsp_if.source)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copy of the translation table and registers.
    logic [31:0] pub_addr;
    logic [15:0] idle_to, plo, phi;
    bit          tv[N_ENTRIES];
    logic [31:0] t_ia[N_ENTRIES], t_ta[N_ENTRIES], t_used[N_ENTRIES];
    logic [15:0] t_ip[N_ENTRIES], t_tp[N_ENTRIES], t_pp[N_ENTRIES];

    t_expect pending[$];
    int      errors = 0;
    int      cycles = 0;
    bit      rsp_stall_on = 1'b1;

    initial begin
        req_if.valid = 1'b0;
        req_if.kind = KIND_OUTBOUND;
        req_if.now_seconds = '0;
        req_if.inner_addr = '0;
        req_if.inner_port = '0;
        req_if.tunnel_addr = '0;
        req_if.tunnel_port = '0;
        req_if.outer_addr = '0;
        req_if.outer_port = '0;
        rsp_if.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic bit port_taken(logic [15:0] p);
        for (int i = 0; i < N_ENTRIES; i++)
            if (tv[i] && t_pp[i] == p) return 1'b1;
        return 1'b0;
    endfunction

    function automatic t_expect translate(logic kind, logic [31:0] now, logic [31:0] ia,
                                          logic [15:0] ip, logic [31:0] ta, logic [15:0] tp,
                                          logic [31:0] oa, logic [15:0] op);
        t_expect r;
        int slot;
        logic [16:0] cand;
        int tries;
        r = '{ST_FAIL, 32'd0, 16'd0, 32'd0, 16'd0};
        if (kind == KIND_INBOUND) begin
            r.status = ST_MISS;
            if (oa == pub_addr)
                for (int i = 0; i < N_ENTRIES; i++)
                    if (tv[i] && t_pp[i] == op && ({1'b0, t_used[i]} + idle_to) > {1'b0, now}) begin
                        t_used[i] = now;
                        r = '{ST_HIT, t_ia[i], t_ip[i], t_ta[i], t_tp[i]};
                        return r;
                    end
            return r;
        end
        for (int i = 0; i < N_ENTRIES; i++)
            if (tv[i] && t_ia[i] == ia && t_ip[i] == ip && t_ta[i] == ta && t_tp[i] == tp) begin
                t_used[i] = now;
                r = '{ST_HIT, pub_addr, t_pp[i], 32'd0, 16'd0};
                return r;
            end
        for (int i = 0; i < N_ENTRIES; i++)
            if (tv[i] && ({1'b0, t_used[i]} + idle_to) < {1'b0, now}) tv[i] = 1'b0;
        slot = -1;
        for (int i = 0; i < N_ENTRIES; i++)
            if (!tv[i]) begin
                slot = i;
                break;
            end
        if (slot < 0) return r;
        cand = {1'b0, plo};
        for (tries = 0; tries < N_ENTRIES && cand <= {1'b0, phi}; tries++) begin
            if (!port_taken(cand[15:0])) break;
            cand++;
        end
        if (tries >= N_ENTRIES || cand > {1'b0, phi}) return r;
        tv[slot] = 1'b1;
        t_ia[slot] = ia;
        t_ip[slot] = ip;
        t_ta[slot] = ta;
        t_tp[slot] = tp;
        t_pp[slot] = cand[15:0];
        t_used[slot] = now;
        r = '{ST_NEW, pub_addr, cand[15:0], 32'd0, 16'd0};
        return r;
    endfunction

    // Response checker with random back-pressure.
    initial begin
        int hold;
        t_expect e;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            hold = rsp_stall_on ? $urandom_range(0, 12) : 0;
            rsp_if.ready = 1'b0;
            repeat (hold) @(negedge i_clk);
            rsp_if.ready = 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
            if (pending.size() == 0) begin
                $error("response with no request outstanding");
                errors++;
            end else begin
                e = pending.pop_front();
                if (rsp_if.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, rsp_if.status);
                    errors++;
                end
                if (rsp_if.result_addr !== e.addr) begin
                    $error("result_addr exp %h got %h", e.addr, rsp_if.result_addr);
                    errors++;
                end
                if (rsp_if.result_port !== e.port) begin
                    $error("result_port exp %h got %h", e.port, rsp_if.result_port);
                    errors++;
                end
                if (rsp_if.result_tunnel_addr !== e.taddr) begin
                    $error("result_tunnel_addr exp %h got %h", e.taddr,
                           rsp_if.result_tunnel_addr);
                    errors++;
                end
                if (rsp_if.result_tunnel_port !== e.tport) begin
                    $error("result_tunnel_port exp %h got %h", e.tport,
                           rsp_if.result_tunnel_port);
                    errors++;
                end
            end
        end
    end

    bit req_gaps_on = 1'b1;

    task automatic send_request(logic kind, logic [31:0] now, logic [31:0] ia, logic [15:0] ip,
                                logic [31:0] ta, logic [15:0] tp, logic [31:0] oa,
                                logic [15:0] op);
        int gap;
        gap = req_gaps_on ? $urandom_range(0, 12) : 0;
        repeat (gap) @(negedge i_clk);
        req_if.valid = 1'b1;
        req_if.kind = kind;
        req_if.now_seconds = now;
        req_if.inner_addr = ia;
        req_if.inner_port = ip;
        req_if.tunnel_addr = ta;
        req_if.tunnel_port = tp;
        req_if.outer_addr = oa;
        req_if.outer_port = op;
        do @(posedge i_clk); while (!req_if.ready);
        pending.push_back(translate(kind, now, ia, ip, ta, tp, oa, op));
        @(negedge i_clk);
        req_if.valid = 1'b0;
    endtask

    task automatic outbound(logic [31:0] now, logic [31:0] ia, logic [15:0] ip,
                            logic [31:0] ta, logic [15:0] tp);
        send_request(KIND_OUTBOUND, now, ia, ip, ta, tp, $urandom, 16'($urandom));
    endtask

    task automatic inbound(logic [31:0] now, logic [31:0] oa, logic [15:0] op);
        send_request(KIND_INBOUND, now, $urandom, 16'($urandom), $urandom, 16'($urandom),
                     oa, op);
    endtask

    task automatic wait_idle();
        while (pending.size() != 0) @(negedge i_clk);
        repeat (3 * N_ENTRIES + 10) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PUBLIC_ADDR:  pub_addr = val;
            CFG_IDLE_TIMEOUT: idle_to = val[15:0];
            CFG_PORT_LOW:     plo = val[15:0];
            default:          phi = val[15:0];
        endcase
    endtask

    task automatic set_config(logic [31:0] pa, logic [15:0] to, logic [15:0] lo,
                              logic [15:0] hi);
        wait_idle();
        write_reg(CFG_PUBLIC_ADDR, pa);
        write_reg(CFG_IDLE_TIMEOUT, {16'd0, to});
        write_reg(CFG_PORT_LOW, {16'd0, lo});
        write_reg(CFG_PORT_HIGH, {16'd0, hi});
    endtask

    task automatic test_directed();
        inbound(32'd10, 32'd0, 16'd1024);
        outbound(32'd10, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        outbound(32'd11, 32'd0, 16'd0, 32'd0, 16'd0);
        outbound(32'd12, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        inbound(32'd13, 32'd0, 16'd1024);
        inbound(32'd13, 32'd1, 16'd1024);
        inbound(32'd13, 32'd0, 16'd1025);
        // The first entry runs out; outbound hit still refreshes it.
        inbound(32'd400, 32'd0, 16'd1024);
        outbound(32'd400, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        // A miss sweeps the expired second entry and reuses its port.
        outbound(32'd500, 32'h1234_5678, 16'd7, 32'h9ABC_DEF0, 16'd9);
        outbound(32'hFFFF_FFFF, 32'h5, 16'd5, 32'h5, 16'd5);
        inbound(32'hFFFF_FFFF, 32'd0, 16'd1024);
        set_config(32'hC0A8_0001, 16'd65535, 16'd3, 16'd1);
        outbound(32'd1, 32'd77, 16'd77, 32'd77, 16'd77);
        set_config(32'hC0A8_0001, 16'd0, 16'd0, 16'd1);
        outbound(32'd1, 32'd1, 16'd1, 32'd1, 16'd1);
        inbound(32'd1, 32'hC0A8_0001, 16'd0);
        outbound(32'd1, 32'd2, 16'd2, 32'd2, 16'd2);
        outbound(32'd1, 32'd3, 16'd3, 32'd3, 16'd3);
        outbound(32'd2, 32'd4, 16'd4, 32'd4, 16'd4);
    endtask

    // Fill the table to its last slot with a wide port range, then overflow it.
    task automatic test_table_full();
        set_config(32'hFFFF_FFFF, 16'd65535, 16'd65535, 16'd65535);
        outbound(32'd5, 32'd9, 16'd9, 32'd9, 16'd9);
        outbound(32'd5, 32'd8, 16'd9, 32'd9, 16'd9);
        set_config(32'h0A00_0001, 16'd65535, 16'd1, 16'd65535);
        req_gaps_on = 1'b0;
        rsp_stall_on = 1'b0;
        for (int i = 0; i < N_ENTRIES + 2; i++)
            outbound(32'd100, i, 16'(i), 32'hAB, 16'd1);
        req_gaps_on = 1'b1;
        rsp_stall_on = 1'b1;
        inbound(32'd100, 32'h0A00_0001, 16'd1);
    endtask

    // Small client pool so that hits, refreshes, expiry and reuse all recur.
    task automatic test_random();
        logic [31:0] now;
        int sel;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_config($urandom, 16'd50, 16'd100, 16'd140);
                1: set_config($urandom, 16'd1, 16'd0, 16'd20);
                2: set_config($urandom, 16'd65535, 16'hFFF0, 16'hFFFF);
                default: set_config($urandom, 16'd300, 16'd1024, 16'd65535);
            endcase
            now = $urandom_range(0, 1000);
            for (int n = 0; n < 80; n++) begin
                sel = $urandom_range(0, 15);
                now = now + $urandom_range(0, 10);
                if (sel == 0) now = $urandom;
                if (sel < 9) begin
                    outbound(now, 32'h0A00_0000 | $urandom_range(0, 7),
                             16'($urandom_range(0, 3)),
                             32'h5000_0000 | $urandom_range(0, 1),
                             16'($urandom_range(0, 1)));
                end else if (sel < 14) begin
                    inbound(now, sel == 13 ? $urandom : pub_addr,
                            plo + 16'($urandom_range(0, 20)));
                end else begin
                    send_request(1'($urandom_range(0, 1)), now, $urandom, 16'($urandom),
                                 $urandom, 16'($urandom), $urandom, 16'($urandom));
                end
                if ((n % 40) == 39) rsp_stall_on = ~rsp_stall_on;
            end
            rsp_stall_on = 1'b1;
        end
    endtask

    initial begin
        pub_addr = 32'd0;
        idle_to = 16'd300;
        plo = 16'd1024;
        phi = 16'd65535;
        foreach (tv[i]) tv[i] = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_table_full();
        test_random();
        wait_idle();
        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule
